@@ hw/rtl/awa_pkg.sv @@
// Shared widths, codes, types and constant tables for the asymmetric window block.
// Used by awa_div and asymmetric_window_apply; depends on nothing else.
package awa_pkg;

    // Field and datapath widths
    localparam int IDX_W     = 16;
    localparam int SMP_W     = 24;
    localparam int COEF_W    = 18;
    localparam int KIND_W    = 4;
    localparam int CFG_W     = IDX_W;
    localparam int CFG_IDX_W = 3;

    // Quarter-wave cosine table geometry
    localparam int COS_DEPTH = 1024;
    localparam int COS_LOG2  = $clog2(COS_DEPTH);
    localparam int COS_AW    = COS_LOG2 + 1;
    localparam int COS_W     = 17;
    localparam int PH_W      = COS_LOG2 + 2;

    // Divider geometry: quotients never exceed 2^16
    localparam int QUO_W     = 17;
    localparam int DEN_W     = 2 * IDX_W + 2;
    localparam int NUM_W     = DEN_W + QUO_W;

    // Cosine-sum arithmetic
    localparam int ACOEF_W   = 20;
    localparam int TERM_W    = ACOEF_W + 1 + COS_W + 1;
    localparam int SUM_W     = TERM_W + 1;
    localparam int PRD_W     = SMP_W + COEF_W;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(65536);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LWIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RWIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LKIND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RKIND  = 3'd4;

    // Window type codes
    localparam logic [KIND_W-1:0] KIND_RECT     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_BARTLETT = 4'd1;
    localparam logic [KIND_W-1:0] KIND_WELCH    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_HANN     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_FLATTOP  = 4'd9;

    // Data that rides alongside the divider pipeline
    typedef struct packed {
        logic signed [SMP_W-1:0] smp;
        logic [KIND_W-1:0]       kind;
        logic                    zero;
        logic [IDX_W-1:0]        w;
    } t_side;

    // Quarter-wave cosine table, Q16, built at elaboration by a Taylor series in Q30
    typedef logic [COS_W-1:0] t_cos_tab [0:COS_DEPTH];

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    function automatic t_cos_tab build_cos_tab();
        t_cos_tab        tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sm;
        longint          e;
        int              j;
        int              k;
        for (j = 0; j <= COS_DEPTH; j++) begin
            x    = (PI_HALF_Q30 * 64'(j) + 64'(COS_DEPTH / 2)) / 64'(COS_DEPTH);
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sm   = longint'(term);
            for (k = 1; k <= 12; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
                if ((k & 1) == 1) begin
                    sm = sm - longint'(term);
                end else begin
                    sm = sm + longint'(term);
                end
            end
            e = (sm + 64'sd8192) >>> 14;
            if (e < 0) begin
                e = 0;
            end
            if (e > 65536) begin
                e = 65536;
            end
            tab[j] = COS_W'(e);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

    // Cosine-sum weights a0..a4 in Q20, one row per type from Hann onward; last row unused
    localparam longint unsigned QSCALE = 64'd1048576;

    typedef logic [ACOEF_W-1:0] t_acoef_tab [0:7][0:4];

    localparam t_acoef_tab A_TAB = '{
        '{ACOEF_W'((64'd5 * QSCALE + 64'd5) / 64'd10),
          ACOEF_W'((64'd5 * QSCALE + 64'd5) / 64'd10),
          ACOEF_W'(0), ACOEF_W'(0), ACOEF_W'(0)},
        '{ACOEF_W'((64'd54 * QSCALE + 64'd50) / 64'd100),
          ACOEF_W'((64'd46 * QSCALE + 64'd50) / 64'd100),
          ACOEF_W'(0), ACOEF_W'(0), ACOEF_W'(0)},
        '{ACOEF_W'((64'd42659 * QSCALE + 64'd50000) / 64'd100000),
          ACOEF_W'((64'd49656 * QSCALE + 64'd50000) / 64'd100000),
          ACOEF_W'((64'd76849 * QSCALE + 64'd500000) / 64'd1000000),
          ACOEF_W'(0), ACOEF_W'(0)},
        '{ACOEF_W'((64'd355768 * QSCALE + 64'd500000) / 64'd1000000),
          ACOEF_W'((64'd487396 * QSCALE + 64'd500000) / 64'd1000000),
          ACOEF_W'((64'd144232 * QSCALE + 64'd500000) / 64'd1000000),
          ACOEF_W'((64'd12604 * QSCALE + 64'd500000) / 64'd1000000),
          ACOEF_W'(0)},
        '{ACOEF_W'((64'd3635819 * QSCALE + 64'd5000000) / 64'd10000000),
          ACOEF_W'((64'd4891775 * QSCALE + 64'd5000000) / 64'd10000000),
          ACOEF_W'((64'd1365995 * QSCALE + 64'd5000000) / 64'd10000000),
          ACOEF_W'((64'd106411 * QSCALE + 64'd5000000) / 64'd10000000),
          ACOEF_W'(0)},
        '{ACOEF_W'((64'd35875 * QSCALE + 64'd50000) / 64'd100000),
          ACOEF_W'((64'd48829 * QSCALE + 64'd50000) / 64'd100000),
          ACOEF_W'((64'd14128 * QSCALE + 64'd50000) / 64'd100000),
          ACOEF_W'((64'd1168 * QSCALE + 64'd50000) / 64'd100000),
          ACOEF_W'(0)},
        '{ACOEF_W'((64'd1000 * QSCALE + 64'd2318) / 64'd4636),
          ACOEF_W'((64'd1930 * QSCALE + 64'd2318) / 64'd4636),
          ACOEF_W'((64'd1290 * QSCALE + 64'd2318) / 64'd4636),
          ACOEF_W'((64'd388 * QSCALE + 64'd2318) / 64'd4636),
          ACOEF_W'((64'd28 * QSCALE + 64'd2318) / 64'd4636)},
        '{ACOEF_W'(0), ACOEF_W'(0), ACOEF_W'(0), ACOEF_W'(0), ACOEF_W'(0)}
    };

endpackage

@@ hw/rtl/awa_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; holds the cosine table copies of the window block.
module awa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // One write and two registered reads per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ hw/rtl/awa_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on awa_pkg for widths and the side-data struct.
module awa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [awa_pkg::NUM_W-1:0]  i_num,
    input  logic [awa_pkg::DEN_W-1:0]  i_den,
    input  awa_pkg::t_side             i_side,
    output logic                       o_vld,
    output logic [awa_pkg::QUO_W-1:0]  o_quo,
    output logic [awa_pkg::DEN_W-1:0]  o_rem,
    output awa_pkg::t_side             o_side
);

    import awa_pkg::*;

    logic             r_vld  [0:QUO_W];
    logic [DEN_W-1:0] r_rem  [0:QUO_W];
    logic [QUO_W-1:0] r_low  [0:QUO_W-1];
    logic [QUO_W-1:0] r_quo  [0:QUO_W];
    logic [DEN_W-1:0] r_den  [0:QUO_W];
    t_side            r_side [0:QUO_W];

    // Entry stage: the caller must keep the upper numerator bits below the divisor; the divider does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_num[NUM_W-1:QUO_W];
        r_low[0]  <= i_num[QUO_W-1:0];
        r_quo[0]  <= '0;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
    end

    // Each stage brings down one numerator bit and tries one subtraction.
    for (genvar g = 0; g < QUO_W; g++) begin : g_step
        logic [DEN_W:0]   w_trial;
        logic             w_ge;
        logic [DEN_W-1:0] n_rem;

        assign w_trial = {r_rem[g], r_low[g][QUO_W-1]};
        assign w_ge    = w_trial >= {1'b0, r_den[g]};
        assign n_rem   = w_ge ? DEN_W'(w_trial - {1'b0, r_den[g]}) : w_trial[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= n_rem;
            r_quo[g+1]  <= {r_quo[g][QUO_W-2:0], w_ge};
            r_den[g+1]  <= r_den[g];
            r_side[g+1] <= r_side[g];
        end

        if (g < QUO_W - 1) begin : g_low
            always_ff @(posedge i_clk) begin
                r_low[g+1] <= {r_low[g][QUO_W-2:0], 1'b0};
            end
        end
    end

    assign o_vld  = r_vld[QUO_W];
    assign o_quo  = r_quo[QUO_W];
    assign o_rem  = r_rem[QUO_W];
    assign o_side = r_side[QUO_W];

endmodule

@@ hw/rtl/asymmetric_window_apply.sv @@
// Top level of the asymmetric window block: config registers, window pipeline, output.
// Depends on awa_pkg, awa_div and awa_ram.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+------------------------------------------
//  request  | start, busy        | i_sample_index, i_sample_value
//  result   | o_strobe           | o_window_coeff, o_windowed_value
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// A request is taken on every cycle that start is high and busy is low, so one sample
// per clock is sustained. Each request passes 27 register stages on its way to the
// outputs: 18 stages of the pipelined divider plus nine datapath stages. After reset,
// busy stays high while both cosine table RAMs are loaded. The receiver cannot stall,
// so the pipeline advances on every clock.
module asymmetric_window_apply (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [awa_pkg::IDX_W-1:0]            i_sample_index,
    input  logic signed [awa_pkg::SMP_W-1:0]     i_sample_value,
    input  logic                                 i_cfg_we,
    input  logic [awa_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [awa_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                 o_strobe,
    output logic signed [awa_pkg::COEF_W-1:0]    o_window_coeff,
    output logic signed [awa_pkg::SMP_W-1:0]     o_windowed_value
);

    import awa_pkg::*;

    localparam int MRW = IDX_W + 3;
    localparam int QPW = QUO_W + 3;
    localparam int RSW = SUM_W - 20;
    localparam int YW  = PRD_W - 16;

    // Configuration registers
    logic [IDX_W-1:0]  r_center;
    logic [IDX_W-1:0]  r_lwidth;
    logic [IDX_W-1:0]  r_rwidth;
    logic [KIND_W-1:0] r_lkind;
    logic [KIND_W-1:0] r_rkind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_lwidth <= '0;
            r_rwidth <= '0;
            r_lkind  <= '0;
            r_rkind  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER: r_center <= i_cfg_data[IDX_W-1:0];
                CFG_LWIDTH: r_lwidth <= i_cfg_data[IDX_W-1:0];
                CFG_RWIDTH: r_rwidth <= i_cfg_data[IDX_W-1:0];
                CFG_LKIND:  r_lkind  <= i_cfg_data[KIND_W-1:0];
                CFG_RKIND:  r_rkind  <= i_cfg_data[KIND_W-1:0];
                default: ;
            endcase
        end
    end

    // Cosine table load after reset, one entry per cycle into both RAM copies.
    logic              r_fill;
    logic [COS_AW-1:0] r_fill_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= 1'b1;
            r_fill_cnt <= '0;
        end else if (r_fill) begin
            if (r_fill_cnt == COS_AW'(COS_DEPTH)) begin
                r_fill <= 1'b0;
            end else begin
                r_fill_cnt <= r_fill_cnt + 1'b1;
            end
        end
    end

    assign busy = r_fill;

    // Stage A: pick the half-window and the distance from the centre.
    logic                    n_a_left;
    logic                    r_a_vld;
    logic signed [SMP_W-1:0] r_a_smp;
    logic [IDX_W-1:0]        r_a_n;
    logic [IDX_W-1:0]        r_a_w;
    logic [KIND_W-1:0]       r_a_kind;

    assign n_a_left = i_sample_index < r_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_smp  <= i_sample_value;
        r_a_n    <= n_a_left ? (r_center - i_sample_index) : (i_sample_index - r_center);
        r_a_w    <= n_a_left ? r_lwidth : r_rwidth;
        r_a_kind <= n_a_left ? r_lkind : r_rkind;
    end

    // Stage B: squares for the Welch window, zero flag for out-of-window or unknown-type samples.
    logic [IDX_W:0]          n_b_d;
    logic                    r_b_vld;
    logic signed [SMP_W-1:0] r_b_smp;
    logic [IDX_W-1:0]        r_b_n;
    logic [IDX_W-1:0]        r_b_w;
    logic [KIND_W-1:0]       r_b_kind;
    logic                    r_b_zero;
    logic [2*IDX_W-1:0]      r_b_n2;
    logic [2*IDX_W:0]        r_b_d2;

    assign n_b_d = {1'b0, r_a_w} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_smp  <= r_a_smp;
        r_b_n    <= r_a_n;
        r_b_w    <= r_a_w;
        r_b_kind <= r_a_kind;
        r_b_zero <= (r_a_n > r_a_w) || (r_a_kind > KIND_FLATTOP);
        r_b_n2   <= r_a_n * r_a_n;
        r_b_d2   <= (2*IDX_W+1)'(n_b_d) * (2*IDX_W+1)'(n_b_d);
    end

    // Stage C: dividend and divisor for the selected window type.
    logic [IDX_W:0]   n_c_d;
    logic [NUM_W-1:0] n_c_num;
    logic [DEN_W-1:0] n_c_den;
    t_side            n_c_side;

    assign n_c_d = {1'b0, r_b_w} + 1'b1;

    always_comb begin
        n_c_num = '0;
        n_c_den = DEN_W'(1);
        unique case (r_b_kind)
            KIND_BARTLETT: begin
                n_c_num = (NUM_W'(n_c_d - {1'b0, r_b_n}) << QUO_W) + NUM_W'(n_c_d);
                n_c_den = DEN_W'(n_c_d) << 1;
            end
            KIND_WELCH: begin
                n_c_num = (NUM_W'(r_b_d2 - {1'b0, r_b_n2}) << QUO_W) + NUM_W'(r_b_d2);
                n_c_den = DEN_W'(r_b_d2) << 1;
            end
            default: begin
                // Cosine-sum types: phase fraction (w - n) * 2 * depth / w.
                if (r_b_kind >= KIND_HANN) begin
                    n_c_num = NUM_W'(r_b_w - r_b_n) << (COS_LOG2 + 1);
                    n_c_den = (r_b_w == '0) ? DEN_W'(1) : DEN_W'(r_b_w);
                end
            end
        endcase
    end

    assign n_c_side = '{smp: r_b_smp, kind: r_b_kind, zero: r_b_zero, w: r_b_w};

    logic             w_d_vld;
    logic [QUO_W-1:0] w_d_quo;
    logic [DEN_W-1:0] w_d_rem;
    t_side            w_d_side;

    awa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_num   (n_c_num),
        .i_den   (n_c_den),
        .i_side  (n_c_side),
        .o_vld   (w_d_vld),
        .o_quo   (w_d_quo),
        .o_rem   (w_d_rem),
        .o_side  (w_d_side)
    );

    // Stage E: rounded phase of each harmonic from one quotient and remainder.
    logic [PH_W-1:0]         n_e_p [0:3];
    logic                    r_e_vld;
    logic [PH_W-1:0]         r_e_p [0:3];
    logic signed [SMP_W-1:0] r_e_smp;
    logic [KIND_W-1:0]       r_e_kind;
    logic                    r_e_zero;
    logic [QUO_W-1:0]        r_e_quo;

    always_comb begin : e_phase
        logic [MRW-1:0] v_mr;
        logic [2:0]     v_cnt;
        for (int i = 0; i < 4; i++) begin
            v_mr  = MRW'(w_d_rem[IDX_W-1:0]) * MRW'(i + 1) + MRW'(w_d_side.w >> 1);
            v_cnt = '0;
            for (int k = 1; k <= 4; k++) begin
                if (v_mr >= MRW'(w_d_side.w) * MRW'(k)) begin
                    v_cnt = v_cnt + 1'b1;
                end
            end
            if (w_d_side.w == '0) begin
                n_e_p[i] = '0;
            end else begin
                n_e_p[i] = PH_W'(QPW'(w_d_quo) * QPW'(i + 1) + QPW'(v_cnt));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_e_p[i] <= n_e_p[i];
        end
        r_e_smp  <= w_d_side.smp;
        r_e_kind <= w_d_side.kind;
        r_e_zero <= w_d_side.zero;
        r_e_quo  <= w_d_quo;
    end

    // Stage F: fold each phase into the quarter wave and read the tables.
    logic [COS_AW-1:0]       n_f_addr [0:3];
    logic                    n_f_neg  [0:3];
    logic [COS_W-1:0]        w_cos    [0:3];
    logic                    r_f_vld;
    logic                    r_f_neg  [0:3];
    logic signed [SMP_W-1:0] r_f_smp;
    logic [KIND_W-1:0]       r_f_kind;
    logic                    r_f_zero;
    logic [QUO_W-1:0]        r_f_quo;

    always_comb begin : f_fold
        logic [1:0]          v_quad;
        logic [COS_LOG2-1:0] v_r;
        for (int i = 0; i < 4; i++) begin
            v_quad      = r_e_p[i][PH_W-1:COS_LOG2];
            v_r         = r_e_p[i][COS_LOG2-1:0];
            n_f_addr[i] = v_quad[0] ? (COS_AW'(COS_DEPTH) - {1'b0, v_r}) : {1'b0, v_r};
            n_f_neg[i]  = v_quad[0] ^ v_quad[1];
        end
    end

    awa_ram #(.WIDTH(COS_W), .DEPTH(COS_DEPTH + 1)) u_cos_lo (
        .i_clk     (i_clk),
        .i_we      (r_fill),
        .i_waddr   (r_fill_cnt),
        .i_wdata   (COS_TAB[r_fill_cnt]),
        .i_raddr_a (n_f_addr[0]),
        .i_raddr_b (n_f_addr[1]),
        .o_rdata_a (w_cos[0]),
        .o_rdata_b (w_cos[1])
    );

    awa_ram #(.WIDTH(COS_W), .DEPTH(COS_DEPTH + 1)) u_cos_hi (
        .i_clk     (i_clk),
        .i_we      (r_fill),
        .i_waddr   (r_fill_cnt),
        .i_wdata   (COS_TAB[r_fill_cnt]),
        .i_raddr_a (n_f_addr[2]),
        .i_raddr_b (n_f_addr[3]),
        .o_rdata_a (w_cos[2]),
        .o_rdata_b (w_cos[3])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_f_neg[i] <= n_f_neg[i];
        end
        r_f_smp  <= r_e_smp;
        r_f_kind <= r_e_kind;
        r_f_zero <= r_e_zero;
        r_f_quo  <= r_e_quo;
    end

    // Stage G: weight each cosine term.
    logic [2:0]               n_g_row;
    logic signed [TERM_W-1:0] n_g_t [0:3];
    logic                     r_g_vld;
    logic signed [TERM_W-1:0] r_g_t [0:3];
    logic [ACOEF_W-1:0]       r_g_a0;
    logic signed [SMP_W-1:0]  r_g_smp;
    logic [KIND_W-1:0]        r_g_kind;
    logic                     r_g_zero;
    logic [QUO_W-1:0]         r_g_quo;

    assign n_g_row = 3'(r_f_kind - KIND_HANN);

    always_comb begin : g_terms
        logic signed [COS_W:0] v_cs;
        for (int i = 0; i < 4; i++) begin
            v_cs     = r_f_neg[i] ? -$signed({1'b0, w_cos[i]}) : $signed({1'b0, w_cos[i]});
            n_g_t[i] = $signed({1'b0, A_TAB[n_g_row][i+1]}) * v_cs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_g_t[i] <= n_g_t[i];
        end
        r_g_a0   <= A_TAB[n_g_row][0];
        r_g_smp  <= r_f_smp;
        r_g_kind <= r_f_kind;
        r_g_zero <= r_f_zero;
        r_g_quo  <= r_f_quo;
    end

    // Stage H: alternating sum of the terms in Q36.
    logic signed [SUM_W-1:0] n_h_sum;
    logic                    r_h_vld;
    logic signed [SUM_W-1:0] r_h_sum;
    logic signed [SMP_W-1:0] r_h_smp;
    logic [KIND_W-1:0]       r_h_kind;
    logic                    r_h_zero;
    logic [QUO_W-1:0]        r_h_quo;

    assign n_h_sum = $signed(SUM_W'({r_g_a0, {(COS_W-1){1'b0}}}))
                   - SUM_W'(r_g_t[0]) + SUM_W'(r_g_t[1])
                   - SUM_W'(r_g_t[2]) + SUM_W'(r_g_t[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_sum  <= n_h_sum;
        r_h_smp  <= r_g_smp;
        r_h_kind <= r_g_kind;
        r_h_zero <= r_g_zero;
        r_h_quo  <= r_g_quo;
    end

    // Stage I: round the sum to Q2.16, clamp, and pick the coefficient by type (zero if flagged).
    logic signed [SUM_W-1:0]  n_i_t;
    logic signed [RSW-1:0]    n_i_rs;
    logic signed [COEF_W-1:0] n_i_cos;
    logic signed [COEF_W-1:0] n_i_coef;
    logic                     r_i_vld;
    logic signed [COEF_W-1:0] r_i_coef;
    logic signed [SMP_W-1:0]  r_i_smp;

    assign n_i_t  = r_h_sum + $signed(SUM_W'(1 << 19));
    assign n_i_rs = n_i_t[SUM_W-1:20];

    always_comb begin
        if ((&n_i_rs[RSW-1:COEF_W-1]) || !(|n_i_rs[RSW-1:COEF_W-1])) begin
            n_i_cos = n_i_rs[COEF_W-1:0];
        end else if (n_i_rs[RSW-1]) begin
            n_i_cos = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            n_i_cos = {1'b0, {(COEF_W-1){1'b1}}};
        end
    end

    always_comb begin
        priority if (r_h_zero) begin
            n_i_coef = '0;
        end else if (r_h_kind == KIND_RECT) begin
            n_i_coef = COEF_ONE;
        end else if (r_h_kind == KIND_BARTLETT || r_h_kind == KIND_WELCH) begin
            n_i_coef = $signed(COEF_W'(r_h_quo));
        end else begin
            n_i_coef = n_i_cos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else begin
            r_i_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_coef <= n_i_coef;
        r_i_smp  <= r_h_smp;
    end

    // Stage J: apply the coefficient to the sample.
    logic                     r_j_vld;
    logic signed [PRD_W-1:0]  r_j_prod;
    logic signed [COEF_W-1:0] r_j_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
        end else begin
            r_j_vld <= r_i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j_prod <= r_i_smp * r_i_coef;
        r_j_coef <= r_i_coef;
    end

    // Stage K: round half up to Q1.23 and saturate into the output register.
    logic signed [PRD_W-1:0]  n_k_t;
    logic signed [YW-1:0]     n_k_y;
    logic signed [SMP_W-1:0]  n_k_val;
    logic                     r_k_vld;
    logic signed [COEF_W-1:0] r_k_coef;
    logic signed [SMP_W-1:0]  r_k_val;

    assign n_k_t = r_j_prod + $signed(PRD_W'(1 << 15));
    assign n_k_y = n_k_t[PRD_W-1:16];

    always_comb begin
        if ((&n_k_y[YW-1:SMP_W-1]) || !(|n_k_y[YW-1:SMP_W-1])) begin
            n_k_val = n_k_y[SMP_W-1:0];
        end else if (n_k_y[YW-1]) begin
            n_k_val = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            n_k_val = {1'b0, {(SMP_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else begin
            r_k_vld <= r_j_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_coef <= r_j_coef;
        r_k_val  <= n_k_val;
    end

    assign o_strobe         = r_k_vld;
    assign o_window_coeff   = r_k_coef;
    assign o_windowed_value = r_k_val;

endmodule
